// ----- design/uvs_pkg.sv -----
`default_nettype none
package uvs_pkg;

  localparam int CNT_W = 10;
  localparam int RAD_W = 16;
  localparam int PH_W = 32;
  localparam int DIV_STEPS = CNT_W + PH_W;
  localparam int Q_W = PH_W + 1;
  localparam int CW = 34;
  localparam int TEX_W = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [PH_W-1:0] TURN_QUARTER = 32'h4000_0000;
  localparam logic [PH_W-1:0] TURN_HALF = 32'h8000_0000;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STACK_COUNT = 2'd0,
    REG_SECTOR_COUNT = 2'd1,
    REG_RADIUS = 2'd2
  } cfg_reg_t;

  // arctangent of 2^-k in 2^-32 turn units
  function automatic logic [PH_W-1:0] atan_turn(input int k);
    logic [PH_W-1:0] a;
    case (k)
      0: a = 32'd536870912;
      1: a = 32'd316933406;
      2: a = 32'd167458907;
      3: a = 32'd85004756;
      4: a = 32'd42667331;
      5: a = 32'd21354465;
      6: a = 32'd10679838;
      7: a = 32'd5340245;
      8: a = 32'd2670163;
      9: a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- design/uv_sphere_vertex_generator.sv -----
// throughput: one vertex per cycle unless the output stalls; 42-stage divider, then two cordic pipelines in parallel
// the whole pipeline holds while a result waits and out_ready is low
// reset: counts 16, radius 1.0, pipeline empty; config port always ready
`default_nettype none
module uv_sphere_vertex_generator #(
  parameter int INDEX_BITS = 10,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [uvs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [uvs_pkg::RAD_W-1:0]       cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [INDEX_BITS-1:0]           stack_index,
  input  wire logic [INDEX_BITS-1:0]           sector_index,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [16:0]                   pos_x,
  output logic signed [16:0]                   pos_y,
  output logic signed [16:0]                   pos_z,
  output logic signed [15:0]                   norm_x,
  output logic signed [15:0]                   norm_y,
  output logic signed [15:0]                   norm_z,
  output logic [uvs_pkg::TEX_W-1:0]            tex_u,
  output logic [uvs_pkg::TEX_W-1:0]            tex_v,
  output logic                                 index_clamped
);

  localparam int CNT_W = uvs_pkg::CNT_W;
  localparam int CLAT = CORDIC_STAGES + 2;
  localparam int P2_IDX = uvs_pkg::DIV_STEPS + 2;
  localparam int LAST = P2_IDX + CLAT + 4;
  localparam int TEX_N = LAST - P2_IDX + 1;
  localparam int XW = (INDEX_BITS > CNT_W) ? INDEX_BITS : CNT_W;
  localparam int CW = uvs_pkg::CW;

  logic [CNT_W-1:0]         stack_count;
  logic [CNT_W-1:0]         sector_count;
  logic [uvs_pkg::RAD_W-1:0] sphere_radius;
  logic [CNT_W-1:0]         stacks;
  logic [CNT_W-1:0]         sectors;

  logic adv;
  logic [LAST:0] vld;
  logic [LAST:0] clmp;

  assign cfg_ready = 1'b1;
  assign adv = !vld[LAST] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[LAST];
  assign index_clamped = clmp[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count <= CNT_W'(16);
      sector_count <= CNT_W'(16);
      sphere_radius <= uvs_pkg::RAD_W'(256);
    end else if (cfg_valid) begin
      unique case (uvs_pkg::cfg_reg_t'(cfg_index))
        uvs_pkg::REG_STACK_COUNT: stack_count <= cfg_data[CNT_W-1:0];
        uvs_pkg::REG_SECTOR_COUNT: sector_count <= cfg_data[CNT_W-1:0];
        uvs_pkg::REG_RADIUS: sphere_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  assign stacks = (stack_count == '0) ? CNT_W'(1) : stack_count;
  assign sectors = (sector_count == '0) ? CNT_W'(1) : sector_count;

  // index clamp
  logic [XW-1:0]    si_ext;
  logic [XW-1:0]    ji_ext;
  logic             i_over;
  logic             j_over;
  logic [CNT_W-1:0] i_sel;
  logic [CNT_W-1:0] j_sel;
  logic [CNT_W-1:0] i0;
  logic [CNT_W-1:0] j0;

  assign si_ext = XW'(stack_index);
  assign ji_ext = XW'(sector_index);
  assign i_over = si_ext > XW'(stacks);
  assign j_over = ji_ext > XW'(sectors);
  assign i_sel = i_over ? stacks : si_ext[CNT_W-1:0];
  assign j_sel = j_over ? sectors : ji_ext[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      clmp <= {clmp[LAST-1:0], i_over || j_over};
      i0 <= i_sel;
      j0 <= j_sel;
    end
  end

  logic [uvs_pkg::Q_W-1:0] q_s;
  logic [uvs_pkg::Q_W-1:0] q_c;
  logic [CNT_W-1:0]        r_s;
  logic [CNT_W-1:0]        r_c;

  uvs_div u_div_stack (
    .clk (clk), .en (adv), .num (i0), .den (stacks), .quot (q_s), .rem (r_s)
  );

  uvs_div u_div_sector (
    .clk (clk), .en (adv), .num (j0), .den (sectors), .quot (q_c), .rem (r_c)
  );

  // P1: low quotient bits back to remainder scale for the texture rounding
  logic [uvs_pkg::Q_W-1:0] q_s1;
  logic [uvs_pkg::Q_W-1:0] q_c1;
  logic [CNT_W-1:0]        r_s1;
  logic [CNT_W-1:0]        r_c1;
  logic [25:0]             mu_s;
  logic [25:0]             mu_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      q_s1 <= q_s;
      q_c1 <= q_c;
      r_s1 <= r_s;
      r_c1 <= r_c;
      mu_s <= q_s[15:0] * stacks;
      mu_c <= q_c[15:0] * sectors;
    end
  end

  // P2: rounded phases and texture coordinates
  logic [CNT_W-1:0] h_s;
  logic [CNT_W-1:0] h_c;
  logic [CNT_W:0]   r31;
  logic             inc_pc;
  logic             inc_ps;
  logic             inc_tu;
  logic             inc_tv;
  logic [31:0]      q31;
  logic [31:0]      ps_n;
  logic [31:0]      pc_n;
  logic [31:0]      ps;
  logic [31:0]      pc;
  logic [uvs_pkg::TEX_W-1:0] tex_u_sr [TEX_N];
  logic [uvs_pkg::TEX_W-1:0] tex_v_sr [TEX_N];

  assign h_s = stacks >> 1;
  assign h_c = sectors >> 1;
  assign inc_pc = (12'(r_c1) + 12'(h_c)) >= 12'(sectors);
  // r31 is twice the remainder of the half-turn division
  assign r31 = q_s1[0] ? (CNT_W+1)'(r_s1) + (CNT_W+1)'(stacks) : (CNT_W+1)'(r_s1);
  assign inc_ps = (12'(r31) + {1'b0, h_s, 1'b0}) >= {1'b0, stacks, 1'b0};
  assign q31 = q_s1[uvs_pkg::Q_W-1:1];
  assign pc_n = q_c1[31:0] + 32'(inc_pc);
  assign ps_n = uvs_pkg::TURN_QUARTER - (q31 + 32'(inc_ps));
  // mu + r is the texture remainder scaled by 2^16
  assign inc_tu = (27'(mu_c) + 27'(r_c1) + {1'b0, h_c, 16'd0}) >= {1'b0, sectors, 16'd0};
  assign inc_tv = (27'(mu_s) + 27'(r_s1) + {1'b0, h_s, 16'd0}) >= {1'b0, stacks, 16'd0};

  always_ff @(posedge clk) begin
    if (adv) begin
      pc <= pc_n;
      ps <= ps_n;
      tex_u_sr[0] <= q_c1[uvs_pkg::Q_W-1:16] + uvs_pkg::TEX_W'(inc_tu);
      tex_v_sr[0] <= q_s1[uvs_pkg::Q_W-1:16] + uvs_pkg::TEX_W'(inc_tv);
      for (int k = 1; k < TEX_N; k++) begin
        tex_u_sr[k] <= tex_u_sr[k-1];
        tex_v_sr[k] <= tex_v_sr[k-1];
      end
    end
  end

  assign tex_u = tex_u_sr[TEX_N-1];
  assign tex_v = tex_v_sr[TEX_N-1];

  logic signed [31:0] cs;
  logic signed [31:0] ss;
  logic signed [31:0] cc;
  logic signed [31:0] sc;

  uvs_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_stack (
    .clk (clk), .en (adv), .phase (ps), .cos_q (cs), .sin_q (ss)
  );

  uvs_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_sector (
    .clk (clk), .en (adv), .phase (pc), .cos_q (cc), .sin_q (sc)
  );

  // M1..M4: direction, scale by radius, round and saturate
  logic signed [63:0] p_x;
  logic signed [63:0] p_y;
  logic signed [31:0] ss1;
  logic signed [CW-1:0] d_x;
  logic signed [CW-1:0] d_y;
  logic signed [CW-1:0] d_z;
  logic signed [50:0] pr_x;
  logic signed [50:0] pr_y;
  logic signed [50:0] pr_z;
  logic signed [15:0] n_x;
  logic signed [15:0] n_y;
  logic signed [15:0] n_z;
  logic signed [16:0] rad_s;

  assign rad_s = $signed({1'b0, sphere_radius});

  function automatic logic signed [15:0] sat_norm(input logic signed [CW-1:0] d);
    logic signed [CW-1:0] t;
    t = (d + CW'(32768)) >>> 16;
    if (t > CW'(16384)) return 16'sd16384;
    if (t < -CW'(16384)) return -16'sd16384;
    return 16'(t);
  endfunction

  function automatic logic signed [16:0] sat_pos(input logic signed [50:0] v);
    logic signed [50:0] t;
    t = (v + 51'sd536870912) >>> 30;
    if (t > 51'sd65535) return 17'sd65535;
    if (t < -51'sd65536) return -17'sd65536;
    return 17'(t);
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      p_x <= cs * cc;
      p_y <= cs * sc;
      ss1 <= ss;
      d_x <= CW'((p_x + 64'sd536870912) >>> 30);
      d_y <= CW'((p_y + 64'sd536870912) >>> 30);
      d_z <= CW'(ss1);
      pr_x <= rad_s * d_x;
      pr_y <= rad_s * d_y;
      pr_z <= rad_s * d_z;
      n_x <= sat_norm(d_x);
      n_y <= sat_norm(d_y);
      n_z <= sat_norm(d_z);
      pos_x <= sat_pos(pr_x);
      pos_y <= sat_pos(pr_y);
      pos_z <= sat_pos(pr_z);
      norm_x <= n_x;
      norm_y <= n_y;
      norm_z <= n_z;
    end
  end

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("pipeline not empty after reset");

  a_tex_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tex_u <= 17'd65536) && (tex_v <= 17'd65536))
    else $error("texture coordinate above one");

  a_ready_path: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

endmodule
`default_nettype wire

// ----- design/uvs_div.sv -----
`default_nettype none
// restoring divider, one quotient bit per stage: quot = floor(num * 2^32 / den)
module uvs_div (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [uvs_pkg::CNT_W-1:0]      num,
  input  wire logic [uvs_pkg::CNT_W-1:0]      den,
  output logic      [uvs_pkg::Q_W-1:0]        quot,
  output logic      [uvs_pkg::CNT_W-1:0]      rem
);

  localparam int N = uvs_pkg::DIV_STEPS;
  localparam int W = uvs_pkg::CNT_W;

  logic [W-1:0] num_r [N];
  logic [W-1:0] rem_r [N];
  logic [N-1:0] q_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [W-1:0] num_in;
    logic [W-1:0] rem_in;
    logic [N-1:0] q_in;
    logic         nbit;
    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         ge;

    if (k == 0) begin : g_first
      assign num_in = num;
      assign rem_in = '0;
      assign q_in = '0;
    end else begin : g_rest
      assign num_in = num_r[k-1];
      assign rem_in = rem_r[k-1];
      assign q_in = q_r[k-1];
    end

    if (k < W) begin : g_bit
      assign nbit = num_in[W-1-k];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    assign trial = {rem_in, nbit};
    assign ge = trial >= {1'b0, den};
    assign diff = trial - {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= num_in;
        rem_r[k] <= ge ? diff[W-1:0] : trial[W-1:0];
        q_r[k] <= {q_in[N-2:0], ge};
      end
    end
  end

  assign quot = q_r[N-1][uvs_pkg::Q_W-1:0];
  assign rem = rem_r[N-1];

endmodule
`default_nettype wire

// ----- design/uvs_cordic.sv -----
`default_nettype none
// rotation cordic, cos and sin in Q30 of a phase in 2^-32 turn
module uvs_cordic #(
  parameter int STAGES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [uvs_pkg::PH_W-1:0]      phase,
  output logic signed [uvs_pkg::PH_W-1:0]    cos_q,
  output logic signed [uvs_pkg::PH_W-1:0]    sin_q
);

  localparam int W = uvs_pkg::CW;

  logic [uvs_pkg::PH_W-1:0] ph_plus;
  logic                     fold;
  logic [uvs_pkg::PH_W-1:0] ph_fold;
  logic signed [W-1:0]      z0;
  logic                     flip0;

  logic signed [W-1:0] x_r [STAGES];
  logic signed [W-1:0] y_r [STAGES];
  logic signed [W-1:0] z_r [STAGES];
  logic                f_r [STAGES];

  assign ph_plus = phase + uvs_pkg::TURN_QUARTER;
  assign fold = ph_plus[uvs_pkg::PH_W-1];
  assign ph_fold = fold ? phase - uvs_pkg::TURN_HALF : phase;

  always_ff @(posedge clk) begin
    if (en) begin
      z0 <= W'($signed(ph_fold));
      flip0 <= fold;
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_rot
    logic signed [W-1:0] x_in;
    logic signed [W-1:0] y_in;
    logic signed [W-1:0] z_in;
    logic                f_in;
    logic signed [W-1:0] at;

    if (k == 0) begin : g_first
      assign x_in = uvs_pkg::CORDIC_X0;
      assign y_in = '0;
      assign z_in = z0;
      assign f_in = flip0;
    end else begin : g_rest
      assign x_in = x_r[k-1];
      assign y_in = y_r[k-1];
      assign z_in = z_r[k-1];
      assign f_in = f_r[k-1];
    end

    assign at = W'(uvs_pkg::atan_turn(k));

    always_ff @(posedge clk) begin
      if (en) begin
        f_r[k] <= f_in;
        if (!z_in[W-1]) begin
          x_r[k] <= x_in - (y_in >>> k);
          y_r[k] <= y_in + (x_in >>> k);
          z_r[k] <= z_in - at;
        end else begin
          x_r[k] <= x_in + (y_in >>> k);
          y_r[k] <= y_in - (x_in >>> k);
          z_r[k] <= z_in + at;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= uvs_pkg::PH_W'(f_r[STAGES-1] ? -x_r[STAGES-1] : x_r[STAGES-1]);
      sin_q <= uvs_pkg::PH_W'(f_r[STAGES-1] ? -y_r[STAGES-1] : y_r[STAGES-1]);
    end
  end

endmodule
`default_nettype wire
